FILE: sv/sia_pkg.sv
package sia_pkg;

    localparam int          MAX_DIGITS  = 10;
    localparam int          CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int          IDX_W       = $clog2(MAX_DIGITS);
    // floor(x * RECIP >> RECIP_SHIFT) == x / 10 for every 32-bit unsigned x
    localparam logic [31:0] RECIP       = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam logic [7:0]  ASCII_ZERO  = 8'h30;
    localparam logic [7:0]  ASCII_MINUS = 8'h2D;

    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic neg;
        logic q_zero;
        logic last;
    } status_t;

endpackage

FILE: sv/signed_int_to_decimal_ascii_unit.sv
// Converts one signed 32-bit word to its decimal ASCII text, most significant
// character first, with a leading '-' for negative values and no leading zeros.
// A word is taken when start is high and busy is low. Each character appears on
// character/last_char for exactly one cycle with strobe high; last_char marks the
// final one. The receiver cannot stall, so characters leave at one per cycle.
// Digits are found by a reciprocal multiply by 1/10, a multiply step then a
// remainder-and-store step per digit, then emitted, and the last character is
// on the outputs in the first cycle with busy low.
module signed_int_to_decimal_ascii_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] value,
    output logic [7:0]         character,
    output logic               last_char,
    output logic               strobe
);
    import sia_pkg::*;

    cmd_t    cmd;
    status_t status;

    sia_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    sia_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .character (character),
        .last_char (last_char),
        .strobe    (strobe)
    );

endmodule

FILE: sv/sia_ctrl.sv
module sia_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output sia_pkg::cmd_t    cmd,
    input  sia_pkg::status_t status
);
    import sia_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_SIGN = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div = 1'b1;
                if (status.q_zero)
                begin
                    state_next = status.neg ? S_SIGN : S_EMIT;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_SIGN:
            begin
                cmd.emit_sign = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit_digit = 1'b1;
                if (status.last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: sv/sia_datapath.sv
module sia_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic signed [31:0] value,
    input  sia_pkg::cmd_t     cmd,
    output sia_pkg::status_t  status,
    output logic [7:0]        character,
    output logic              last_char,
    output logic              strobe
);
    import sia_pkg::*;

    logic              neg_reg;
    logic [31:0]       mag_reg, mag_next;
    logic [63:0]       prod_reg;
    logic [CNT_W-1:0]  ndig_reg;
    logic [3:0]        digits_reg [MAX_DIGITS];
    logic [7:0]        character_reg;
    logic              last_char_reg;
    logic              strobe_reg;

    logic [31:0]       quot;
    logic [31:0]       quot_x10;
    logic [31:0]       rem_full;
    logic [IDX_W-1:0]  rd_idx;
    logic [CNT_W-1:0]  rd_cnt;

    assign quot     = 32'(prod_reg >> RECIP_SHIFT);
    assign quot_x10 = {quot[28:0], 3'b000} + {quot[30:0], 1'b0};
    assign rem_full = mag_reg - quot_x10;
    assign rd_cnt   = ndig_reg - CNT_W'(1);
    assign rd_idx   = rd_cnt[IDX_W-1:0];

    // two's complement negate; 0x80000000 maps to itself, which is the right magnitude
    assign mag_next = value[31] ? (32'd0 - 32'(value)) : 32'(value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ndig_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit_sign | cmd.emit_digit;
            if (cmd.load)
            begin
                ndig_reg <= '0;
            end
            else if (cmd.div)
            begin
                ndig_reg <= ndig_reg + CNT_W'(1);
            end
            else if (cmd.emit_digit)
            begin
                ndig_reg <= rd_cnt;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg <= value[31];
            mag_reg <= mag_next;
        end
        else if (cmd.div)
        begin
            mag_reg <= quot;
        end
        if (cmd.mul)
        begin
            prod_reg <= mag_reg * RECIP;
        end
        // digit k of the number goes to slot k, least significant at slot 0
        if (cmd.div)
        begin
            digits_reg[ndig_reg[IDX_W-1:0]] <= rem_full[3:0];
        end
        if (cmd.emit_sign)
        begin
            character_reg <= ASCII_MINUS;
            last_char_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            character_reg <= ASCII_ZERO + {4'd0, digits_reg[rd_idx]};
            last_char_reg <= (ndig_reg == CNT_W'(1));
        end
    end

    assign status.neg    = neg_reg;
    assign status.q_zero = (quot == 32'd0);
    assign status.last   = (ndig_reg == CNT_W'(1));

    assign character = character_reg;
    assign last_char = last_char_reg;
    assign strobe    = strobe_reg;

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (character == ASCII_MINUS) ||
                   ((character >= ASCII_ZERO) && (character <= ASCII_ZERO + 8'd9)))
        else $error("bad character on output");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && character == ASCII_MINUS) |-> !last_char)
        else $error("minus sign marked last");

    a_ndig_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ndig_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count overflow");

    a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_digit |-> (ndig_reg != '0))
        else $error("digit emitted with empty digit store");

    a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_sign |=> cmd.emit_digit)
        else $error("minus sign not followed by a digit");

endmodule
